// ===== src/sync_word_packet_deframer_top_macros.svh =====
// Assertion macros for the sync-word deframer checker.
// Depends on nothing; included by files that assert.
`ifndef SYNC_WORD_PACKET_DEFRAMER_TOP_MACROS_SVH
`define SYNC_WORD_PACKET_DEFRAMER_TOP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SWPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define SWPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/swpd_pkg.sv =====
// Shared types and constants for the sync-word packet deframer.
// No dependencies; used by every module of the block.
package swpd_pkg;

    // Total frame length in bytes, sync word included.
    localparam int FRAME_BYTES = 32;
    localparam int PAYLOAD_LEN = FRAME_BYTES - 4;
    localparam logic [6:0] LAST_INDEX = 7'(PAYLOAD_LEN - 1);

    localparam logic [31:0] SYNC_WORD_RESET   = 32'h5F43_4D44;
    localparam logic [15:0] LINK_RELOAD_RESET = 16'd400;

    // Configuration register indexes.
    localparam logic CFG_SYNC_WORD   = 1'b0;
    localparam logic CFG_LINK_RELOAD = 1'b1;

    // Input beat kinds (tuser).
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [6:0]  byte_index;
        logic        frame_end;
        logic        in_sync;
        logic [15:0] link_timer;
    } t_result;

endpackage

// ===== src/swpd_skid.sv =====
// Two-entry output buffer: result register plus skid register.
// Depends on swpd_pkg (t_result).
module swpd_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  swpd_pkg::t_result i_in_data,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output swpd_pkg::t_result o_out_data
);

    logic              r_out_vld, n_out_vld;
    logic              r_skid_vld, n_skid_vld;
    swpd_pkg::t_result r_out, n_out;
    swpd_pkg::t_result r_skid, n_skid;
    logic              load;

    assign o_in_ready  = !r_skid_vld;
    assign load        = i_in_valid && !r_skid_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (!r_out_vld || i_out_ready) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out     = i_in_data;
                n_out_vld = load;
            end
        end else if (load) begin
            n_skid     = i_in_data;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

// ===== src/swpd_core.sv =====
// Sync hunt, payload counter, link timer and configuration registers.
// Depends on swpd_pkg (constants, t_result).
module swpd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              i_accept,
    input  logic              i_req_type,
    input  logic [7:0]        i_byte_value,
    output swpd_pkg::t_result o_result
);

    logic [31:0] r_sync_word;
    logic [15:0] r_link_reload;

    logic        r_synced, n_synced;
    logic [1:0]  r_match, n_match;
    logic [6:0]  r_pcount, n_pcount;
    logic        r_frame_seen, n_frame_seen;
    logic [15:0] r_alive, n_alive;

    logic [7:0]  exp_byte;
    logic [7:0]  first_byte;
    logic [7:0]  pcount_inc;

    assign first_byte = r_sync_word[31:24];
    assign pcount_inc = {1'b0, r_pcount} + 8'd1;

    always_comb begin
        case (r_match)
            2'd0:    exp_byte = r_sync_word[31:24];
            2'd1:    exp_byte = r_sync_word[23:16];
            2'd2:    exp_byte = r_sync_word[15:8];
            default: exp_byte = r_sync_word[7:0];
        endcase
    end

    always_comb begin
        n_synced     = r_synced;
        n_match      = r_match;
        n_pcount     = r_pcount;
        n_frame_seen = r_frame_seen;
        n_alive      = r_alive;
        o_result     = '0;

        if (i_req_type == swpd_pkg::REQ_TICK) begin
            if (r_frame_seen) begin
                n_alive = r_link_reload;
            end else if (r_alive != 16'd0) begin
                n_alive = r_alive - 16'd1;
            end
            n_frame_seen = 1'b0;
        end else if (r_synced) begin
            o_result.payload_valid = 1'b1;
            o_result.payload_byte  = i_byte_value;
            o_result.byte_index    = r_pcount;
            n_pcount               = pcount_inc[6:0];
            if (pcount_inc >= 8'(swpd_pkg::PAYLOAD_LEN)) begin
                o_result.frame_end = 1'b1;
                n_synced           = 1'b0;
                n_pcount           = '0;
                n_match            = '0;
                n_frame_seen       = 1'b1;
            end
        end else begin
            if (i_byte_value == exp_byte) begin
                // Last sync byte: lock and start the payload count.
                if (r_match == 2'd3) begin
                    n_synced = 1'b1;
                    n_match  = '0;
                    n_pcount = '0;
                end else begin
                    n_match = r_match + 2'd1;
                end
            end else if (i_byte_value == first_byte) begin
                n_match = 2'd1;
            end else begin
                n_match  = '0;
                n_pcount = '0;
            end
        end

        o_result.in_sync    = n_synced;
        o_result.link_timer = n_alive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word   <= swpd_pkg::SYNC_WORD_RESET;
            r_link_reload <= swpd_pkg::LINK_RELOAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                swpd_pkg::CFG_SYNC_WORD:   r_sync_word   <= i_cfg_wdata;
                swpd_pkg::CFG_LINK_RELOAD: r_link_reload <= i_cfg_wdata[15:0];
                default:                   r_sync_word   <= r_sync_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced     <= 1'b0;
            r_match      <= '0;
            r_pcount     <= '0;
            r_frame_seen <= 1'b0;
            r_alive      <= '0;
        end else if (i_accept) begin
            r_synced     <= n_synced;
            r_match      <= n_match;
            r_pcount     <= n_pcount;
            r_frame_seen <= n_frame_seen;
            r_alive      <= n_alive;
        end
    end

endmodule

// ===== src/sync_word_packet_deframer_top.sv =====
// Top level of the sync-word packet deframer.
// Depends on swpd_pkg, swpd_core and swpd_skid.
// Usage:
//   Input stream (s_axis_*): each beat is either a received byte
//   (tuser = 0, byte in tdata) or a poll tick for the link timer
//   (tuser = 1, tdata ignored).
//   Output stream (m_axis_*): exactly one beat per input beat, in order.
//   tuser flags a payload byte, tlast marks the last payload byte of a
//   frame, tdata carries the byte, its index, the sync state and the
//   link-alive timer after that input beat.
//   Config port: write sync word (index 0) or link reload (index 1) with
//   i_cfg_we; take effect on the next beat. Write only while idle.
// Timing:
//   Each taken beat's result is registered in the result register, or in
//   the skid register while the receiver stalls. Throughput is one beat per
//   cycle while the receiver does not stall; all deframer state updates
//   happen in the cycle a beat is taken. While the receiver stalls, one more
//   beat is taken, then s_axis_tready drops until the result register drains.
// Reset: i_rst_n low (synchronous) restores the sync word "_CMD" and the
//   reload value 400, clears hunt, frame and timer state, empties the buffer.
module sync_word_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] req_type
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [14:8] byte_index,
                                        // [15] in_sync, [31:16] link_timer
    output logic        m_axis_tuser,   // [0] payload_valid
    output logic        m_axis_tlast    // frame_end
);

    logic              accept;
    swpd_pkg::t_result result;
    swpd_pkg::t_result out_data;

    // Advance the deframer state only on an accepted beat.
    assign accept = s_axis_tvalid && s_axis_tready;

    swpd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_req_type   (s_axis_tuser),
        .i_byte_value (s_axis_tdata),
        .o_result     (result)
    );

    // Hold results here while the receiver stalls.
    swpd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (result),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_data)
    );

    assign m_axis_tdata = {out_data.link_timer, out_data.in_sync,
                           out_data.byte_index, out_data.payload_byte};
    assign m_axis_tuser = out_data.payload_valid;
    assign m_axis_tlast = out_data.frame_end;

endmodule

// ===== src/swpd_checker.sv =====
// Port-level checker for the sync-word packet deframer, bound to the top.
// Depends on swpd_pkg and sync_word_packet_deframer_top_macros.svh.
`include "sync_word_packet_deframer_top_macros.svh"

module swpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // Non-payload beats carry zero byte and index.
    `SWPD_ASSERT(a_idle_fields_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[14:0] == 15'd0), "payload fields set on a non-payload beat")

    // Frame end only on the last payload index, with sync dropped.
    `SWPD_ASSERT(a_last_beat, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser && !m_axis_tdata[15] && m_axis_tdata[14:8] == swpd_pkg::LAST_INDEX), "bad frame end beat")

    // Payload beats before the last keep the sync state.
    `SWPD_ASSERT(a_mid_frame_sync, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser && !m_axis_tlast) |-> m_axis_tdata[15], "sync lost inside a frame")

    // A stalled output beat holds.
    `SWPD_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled output beat changed")

endmodule

bind sync_word_packet_deframer_top swpd_checker u_swpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for sync_word_packet_deframer_top.
// Depends on swpd_pkg and the deframer RTL; drives random stream traffic,
// predicts every result beat and compares it field by field.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int ITEMS_PER_SET  = 235;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 20;

    // One pending line beat: a received byte or a poll tick, plus the idle
    // cycles the sender inserts after it.
    typedef struct {
        logic        tick;
        logic [7:0]  data;
        int unsigned gap;
    } t_line_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] byte_value
    logic        s_axis_tuser = 1'b0;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [7:0] payload_byte, [14:8] byte_index,
                                        // [15] in_sync, [31:16] link_timer
    logic        m_axis_tuser;          // [0] payload_valid
    logic        m_axis_tlast;          // frame_end

    sync_word_packet_deframer_top i_dut (.*);

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Predictor copy of the registers and the deframer state.
    logic [31:0] cfg_sync = swpd_pkg::SYNC_WORD_RESET;
    logic [15:0] cfg_reload = swpd_pkg::LINK_RELOAD_RESET;
    logic        locked = 1'b0;
    logic [2:0]  hunt_cnt = '0;
    logic [6:0]  pay_cnt = '0;
    logic        frame_done = 1'b0;
    logic [15:0] alive = '0;

    t_line_beat        line_q[$];
    swpd_pkg::t_result deframed_q[$];

    int unsigned idle_left = 0;
    int unsigned hold_left = 0;
    int unsigned tx_burst_left = 0;
    int unsigned rx_burst_left = 0;
    int          queued_total = 0;
    int          error_count = 0;
    int          ticks_in = 0;
    int          payload_out = 0;
    int          frames_out = 0;
    int          quiet_cycles = 0;

    function automatic logic [7:0] sync_byte(int unsigned k);
        return 8'(cfg_sync >> (24 - 8 * (k & 3)));
    endfunction

    // Advance the predicted deframer by one line beat and return its result.
    function automatic swpd_pkg::t_result deframe_predict(logic is_tick, logic [7:0] rx_byte);
        swpd_pkg::t_result res;
        res = '0;
        if (is_tick) begin
            if (frame_done) begin
                alive = cfg_reload;
            end else if (alive != 0) begin
                alive = alive - 16'd1;
            end
            frame_done = 1'b0;
        end else if (locked) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte;
            res.byte_index    = pay_cnt;
            pay_cnt = pay_cnt + 7'd1;
            if (pay_cnt >= 7'(swpd_pkg::PAYLOAD_LEN)) begin
                res.frame_end = 1'b1;
                locked     = 1'b0;
                pay_cnt    = '0;
                hunt_cnt   = '0;
                frame_done = 1'b1;
            end
        end else if (hunt_cnt < 3'd4 && rx_byte == sync_byte(hunt_cnt)) begin
            hunt_cnt = hunt_cnt + 3'd1;
            if (hunt_cnt >= 3'd4) begin
                locked   = 1'b1;
                hunt_cnt = '0;
                pay_cnt  = '0;
            end
        end else if (rx_byte == sync_byte(0)) begin
            // Mismatch on a byte that starts the word again: restart at one.
            hunt_cnt = 3'd1;
        end else begin
            hunt_cnt = '0;
            pay_cnt  = '0;
        end
        res.in_sync    = locked;
        res.link_timer = alive;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic check_field(string what, longint got, longint want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Sender idle: a random gap after most beats, with stretches of back-to-back beats.
    task automatic queue_beat(logic is_tick, logic [7:0] data);
        t_line_beat lb;
        lb.tick = is_tick;
        lb.data = data;
        if (tx_burst_left != 0) begin
            tx_burst_left--;
            lb.gap = 0;
        end else begin
            lb.gap = $urandom_range(0, 15);
            if ($urandom_range(0, 29) == 0) begin
                tx_burst_left = $urandom_range(8, 40);
            end
        end
        line_q.push_back(lb);
        queued_total++;
    endtask

    task automatic queue_tick();
        queue_beat(swpd_pkg::REQ_TICK, 8'($urandom()));
    endtask

    // Well-formed frame: the sync word, then a full payload, with ticks mixed in for some frames.
    task automatic queue_frame();
        int unsigned tick_odds;
        tick_odds = ($urandom_range(0, 2) == 0) ? 0 : 12;
        for (int k = 0; k < 4; k++) begin
            queue_beat(swpd_pkg::REQ_BYTE, sync_byte(k));
        end
        for (int n = 0; n < swpd_pkg::PAYLOAD_LEN; n++) begin
            if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) begin
                queue_tick();
            end
            if ($urandom_range(0, 7) == 0) begin
                queue_beat(swpd_pkg::REQ_BYTE, sync_byte($urandom_range(0, 3)));
            end else begin
                queue_beat(swpd_pkg::REQ_BYTE, 8'($urandom()));
            end
        end
    endtask

    // Start of a sync word cut short by a stray or restarting byte.
    task automatic queue_broken_sync();
        int unsigned depth;
        depth = $urandom_range(1, 3);
        for (int k = 0; k < depth; k++) begin
            queue_beat(swpd_pkg::REQ_BYTE, sync_byte(k));
        end
        if ($urandom_range(0, 1) == 0) begin
            queue_beat(swpd_pkg::REQ_BYTE, sync_byte(0));
        end else begin
            queue_beat(swpd_pkg::REQ_BYTE, 8'($urandom()));
        end
    endtask

    task automatic queue_noise();
        int unsigned pick;
        repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                queue_tick();
            end else if (pick < 5) begin
                queue_beat(swpd_pkg::REQ_BYTE, sync_byte($urandom_range(0, 3)));
            end else begin
                queue_beat(swpd_pkg::REQ_BYTE, 8'($urandom()));
            end
        end
    endtask

    task automatic queue_random(int count);
        int stop_at;
        int unsigned pick;
        stop_at = queued_total + count;
        while (queued_total < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                queue_frame();
            end else if (pick < 8) begin
                queue_broken_sync();
            end else begin
                queue_noise();
            end
        end
    endtask

    task automatic wait_drained();
        while (line_q.size() != 0 || s_axis_tvalid || deframed_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Register writes happen only with the block idle; the predictor follows at once.
    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == swpd_pkg::CFG_SYNC_WORD) begin
            cfg_sync = value;
        end else begin
            cfg_reload = value[15:0];
        end
    endtask

    // Line driver: hold a beat until taken, then idle for its gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            idle_left = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (idle_left != 0) begin
                s_axis_tvalid <= 1'b0;
                idle_left = idle_left - 1;
            end else if (line_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= line_q[0].data;
                s_axis_tuser  <= line_q[0].tick;
                idle_left = line_q[0].gap;
                void'(line_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: a random stall after each beat, with stall-free stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= (hold_left == 0);
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (rx_burst_left != 0) begin
                rx_burst_left--;
                hold_left = 0;
            end else begin
                hold_left = $urandom_range(0, 15);
                if ($urandom_range(0, 24) == 0) begin
                    rx_burst_left = $urandom_range(10, 60);
                end
            end
            m_axis_tready <= (hold_left == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check each result beat against the oldest prediction, then
    // predict for any line beat taken at this edge.
    always @(posedge i_clk) begin
        swpd_pkg::t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (m_axis_tuser) payload_out++;
                if (m_axis_tlast) frames_out++;
                if (deframed_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending", m_axis_tdata, 0);
                end else begin
                    want = deframed_q.pop_front();
                    check_field("payload_valid", m_axis_tuser, want.payload_valid);
                    check_field("payload_byte", m_axis_tdata[7:0], want.payload_byte);
                    check_field("byte_index", m_axis_tdata[14:8], want.byte_index);
                    check_field("frame_end", m_axis_tlast, want.frame_end);
                    check_field("in_sync", m_axis_tdata[15], want.in_sync);
                    check_field("link_timer", m_axis_tdata[31:16], want.link_timer);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == swpd_pkg::REQ_TICK) ticks_in++;
                deframed_q.push_back(deframe_predict(s_axis_tuser, s_axis_tdata));
            end
        end
    end

    // Watchdog: end the run once nothing has moved on either side for too long.
    initial begin
        wait (i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("[sync_word_packet_deframer_top] ERROR");
        $finish;
    end

    initial begin
        logic [31:0] word;
        logic [15:0] reload;
        logic [7:0]  pa;
        logic [7:0]  pb;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset word "_CMD".
        queue_tick();                           // timer already at zero stays there
        queue_beat(swpd_pkg::REQ_BYTE, 8'h00);
        queue_beat(swpd_pkg::REQ_BYTE, 8'hFF);
        queue_beat(swpd_pkg::REQ_BYTE, sync_byte(0));
        queue_beat(swpd_pkg::REQ_BYTE, sync_byte(1));
        queue_beat(swpd_pkg::REQ_BYTE, sync_byte(0));   // breaks the word but restarts it
        queue_beat(swpd_pkg::REQ_BYTE, sync_byte(1));
        queue_beat(swpd_pkg::REQ_BYTE, sync_byte(2));
        queue_beat(swpd_pkg::REQ_BYTE, sync_byte(3));   // word complete, payload follows
        queue_beat(swpd_pkg::REQ_BYTE, 8'hFF);
        queue_beat(swpd_pkg::REQ_BYTE, 8'h00);
        queue_tick();                           // tick while collecting payload
        for (int k = 0; k < 4; k++) begin
            queue_beat(swpd_pkg::REQ_BYTE, sync_byte(k)); // sync bytes inside payload pass
        end
        for (int n = 6; n < swpd_pkg::PAYLOAD_LEN; n++) begin
            queue_beat(swpd_pkg::REQ_BYTE, 8'($urandom()));
        end
        queue_tick();                           // reload after the completed frame
        queue_tick();                           // then count down
        wait_drained();

        // Random part over several register settings, extremes first.
        for (int set = 0; set < 5; set++) begin
            pa = 8'($urandom());
            pb = 8'($urandom());
            case (set)
                0: begin
                    word   = 32'hFFFF_FFFF;
                    reload = 16'hFFFF;
                end
                1: begin
                    word   = 32'h0000_0000;
                    reload = 16'h0000;
                end
                2: begin
                    word   = $urandom();
                    reload = 16'($urandom_range(1, 4));
                end
                3: begin
                    word   = {pa, pb, pa, pb};  // self-overlapping word
                    reload = 16'($urandom());
                end
                default: begin
                    word   = swpd_pkg::SYNC_WORD_RESET;
                    reload = swpd_pkg::LINK_RELOAD_RESET;
                end
            endcase
            write_reg(swpd_pkg::CFG_SYNC_WORD, word);
            write_reg(swpd_pkg::CFG_LINK_RELOAD, {16'h0000, reload});
            queue_random(ITEMS_PER_SET);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (deframed_q.size() != 0) begin
            report_mismatch("results still pending at end", deframed_q.size(), 0);
        end

        $display("covered %0d line beats (%0d ticks) over 6 register settings",
                 queued_total, ticks_in);
        $display("saw %0d payload bytes in %0d frames, %0d mismatches",
                 payload_out, frames_out, error_count);
        if (error_count == 0) begin
            $display("[sync_word_packet_deframer_top] OK");
        end else begin
            $display("[sync_word_packet_deframer_top] ERROR");
        end
        $finish;
    end

endmodule
